[rtl/pta_pkg.sv]
// Package for the pulse tachometer: payload structs, the queue entry, FSM state types
// and the constants that the front end, the queue and the back end share.
// No dependencies.
`default_nettype none
package pta_pkg;

    localparam int WIDTH_W      = 20;
    localparam int WINDOW_DEF   = 10;
    localparam int WINDOW_MAX   = 64;
    // The running sum holds WINDOW_MAX full-scale widths without wrapping.
    localparam int SUM_W        = WIDTH_W + $clog2(WINDOW_MAX);
    localparam int RECIP_W      = SUM_W + 1;
    localparam int QUEUE_DEPTH  = 2;

    // 26883 * 16: the speed numerator in Q.4.
    localparam logic [18:0] SPEED_NUM   = 19'd430128;
    localparam int          DIV_STEPS   = 19;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [WIDTH_W-1:0] FASTEST_RST = 20'd100;
    localparam logic [WIDTH_W-1:0] SLOWEST_RST = 20'd100000;

    localparam logic REG_FASTEST = 1'b0;
    localparam logic REG_SLOWEST = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_width;
        logic               reverse_dir;
    } t_in;

    typedef struct packed {
        logic [WIDTH_W-1:0]        avg_width;
        logic signed [WIDTH_W-1:0] speed_q4;
        logic                      window_filled;
        logic                      stopped;
    } t_out;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             reverse_dir;
        logic             filled;
    } t_job;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_PREP,
        B_DIV
    } t_bstate;

endpackage
`default_nettype wire

[rtl/pulse_tachometer_average_rpm.sv]
// Top level of the moving-average pulse tachometer: configuration registers,
// front end, job queue and back end. Uses pta_pkg, pta_front, pta_fifo, pta_back.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_in_data   (pta_pkg::t_in)
//   out       output     o_out_valid / i_out_ready   o_out_data  (pta_pkg::t_out)
//   config    input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// The front end reads the old window entry as it accepts an input transaction, then
// writes the new one and updates the running sum, taking nothing new meanwhile. The
// back end handles one item at a time through the 19-step shift-subtract speed divider,
// which a stopped or zero average skips; the divider and output stalls bound the rate.
// A two-entry queue lets the front end keep taking transactions while the back end
// divides or while a result waits in the output register. Reset is synchronous and
// active low; it clears the window index, the sum, the fill flags and all handshake
// state. The window store is not cleared; it counts as zero until the ring index wraps.
`default_nettype none
module pulse_tachometer_average_rpm #(
    parameter int WINDOW = pta_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire pta_pkg::t_in                i_in_data,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      pta_pkg::t_out               o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [pta_pkg::WIDTH_W-1:0] i_cfg_data
);

    logic [pta_pkg::WIDTH_W-1:0] r_fastest;
    logic [pta_pkg::WIDTH_W-1:0] r_slowest;

    logic          q_push, q_full, q_pop, q_valid;
    pta_pkg::t_job push_job, pop_job;

    // Configuration writes land directly; the user must only write while the block is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fastest <= pta_pkg::FASTEST_RST;
            r_slowest <= pta_pkg::SLOWEST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pta_pkg::REG_FASTEST: r_fastest <= i_cfg_data;
                pta_pkg::REG_SLOWEST: r_slowest <= i_cfg_data;
                default: begin
                    r_fastest <= r_fastest;
                end
            endcase
        end
    end

    // Front end: qualifies widths and keeps the ring window and running sum.
    pta_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_fastest  (r_fastest),
        .i_slowest  (r_slowest),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    // Job queue: the front end only accepts a transaction when a slot is free,
    // so a push never finds the queue full.
    pta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // Back end: average, stop detection, speed division and the output register.
    pta_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slowest   (r_slowest),
        .i_q_valid   (q_valid),
        .i_job       (pop_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // A stopped motor always reports zero speed.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stopped |-> o_out_data.speed_q4 == '0)
        else $error("stopped result with nonzero speed");

    // The queue never sees a push while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    // After an accepted input transaction the front end drops ready and pushes the job in the next cycle.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && q_push)
        else $error("front end did not finish the accepted transaction");
`endif

endmodule
`default_nettype wire

[rtl/pta_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module pta_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/pta_front.sv]
// Front end: accepts a pulse width, qualifies it, updates the ring window and the
// running sum, and pushes one job into the queue. Uses pta_pkg and pta_ram.
`default_nettype none
module pta_front #(
    parameter int WINDOW = pta_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire pta_pkg::t_in                i_in_data,
    input  wire logic [pta_pkg::WIDTH_W-1:0] i_fastest,
    input  wire logic [pta_pkg::WIDTH_W-1:0] i_slowest,
    input  wire logic                        i_q_full,
    output      logic                        o_push,
    output      pta_pkg::t_job               o_job
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    pta_pkg::t_fstate r_state, n_state;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic                        r_wrap, n_wrap;
    logic                        r_filled, n_filled;
    logic [pta_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [pta_pkg::WIDTH_W-1:0] r_width, n_width;
    logic                        r_rev, n_rev;

    logic [pta_pkg::WIDTH_W-1:0] ram_rdata;
    logic [pta_pkg::WIDTH_W-1:0] old_width;
    logic                        ram_we;

    // The ring is written in index order, so an entry has been written once the
    // index has wrapped; before that every entry is taken as zero.
    pta_ram #(
        .WIDTH (pta_pkg::WIDTH_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_width),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign old_width = r_wrap ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pta_pkg::F_IDLE;
            r_idx    <= '0;
            r_wrap   <= 1'b0;
            r_filled <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_wrap   <= n_wrap;
            r_filled <= n_filled;
            r_sum    <= n_sum;
        end
        r_width <= n_width;
        r_rev   <= n_rev;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_wrap     = r_wrap;
        n_filled   = r_filled;
        n_sum      = r_sum;
        n_width    = r_width;
        n_rev      = r_rev;
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            pta_pkg::F_IDLE: begin
                o_in_ready = !i_q_full;
                if (i_in_valid && !i_q_full) begin
                    n_width = (i_in_data.pulse_width < i_fastest) ? i_slowest
                                                                  : i_in_data.pulse_width;
                    n_rev   = i_in_data.reverse_dir;
                    n_state = pta_pkg::F_UPD;
                end
            end
            pta_pkg::F_UPD: begin
                ram_we = 1'b1;
                o_push = 1'b1;
                n_sum  = r_sum - pta_pkg::SUM_W'(old_width)
                               + pta_pkg::SUM_W'(r_width);
                if (r_idx == LAST_IDX) begin
                    n_idx  = '0;
                    n_wrap = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
                if (n_idx == LAST_IDX) begin
                    n_filled = 1'b1;
                end
                n_state = pta_pkg::F_IDLE;
            end
            default: begin
                n_state = pta_pkg::F_IDLE;
            end
        endcase
    end

    assign o_job.sum         = n_sum;
    assign o_job.reverse_dir = r_rev;
    assign o_job.filled      = n_filled;

endmodule
`default_nettype wire

[rtl/pta_fifo.sv]
// Short job queue between the front end and the back end.
// Uses pta_pkg for the job type and depth.
`default_nettype none
module pta_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pta_pkg::t_job i_job,
    output      logic          o_full,
    input  wire logic          i_pop,
    output      logic          o_valid,
    output      pta_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(pta_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pta_pkg::QUEUE_DEPTH + 1);

    pta_pkg::t_job    r_mem [pta_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(pta_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(pta_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(pta_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[rtl/pta_back.sv]
// Back end: turns a window sum into the average by a reciprocal multiply, then
// divides the speed numerator by it in a shift-subtract loop. Uses pta_pkg.
`default_nettype none
module pta_back #(
    parameter int WINDOW = pta_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pta_pkg::WIDTH_W-1:0] i_slowest,
    input  wire logic                        i_q_valid,
    input  wire pta_pkg::t_job               i_job,
    output      logic                        o_pop,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      pta_pkg::t_out               o_out_data
);

    // floor(sum / WINDOW) == (sum * RECIP) >> SHIFT for every sum below 2**SUM_W,
    // since the rounding error of RECIP stays below 2**(SHIFT - SUM_W).
    localparam int          SHIFT      = pta_pkg::SUM_W + $clog2(WINDOW);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                         / 64'(WINDOW);
    localparam logic [pta_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[pta_pkg::RECIP_W-1:0];
    localparam int PROD_W = pta_pkg::SUM_W + pta_pkg::RECIP_W;

    pta_pkg::t_bstate r_state, n_state;
    logic                              r_ov, n_ov;
    pta_pkg::t_out                     r_out, n_out;
    pta_pkg::t_job                     r_job, n_job;
    logic [PROD_W-1:0]                 r_prod, n_prod;
    logic [pta_pkg::WIDTH_W-1:0]       r_avg, n_avg;
    logic [pta_pkg::WIDTH_W-1:0]       r_rem, n_rem;
    logic [18:0]                       r_quo, n_quo;
    logic [pta_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic                              r_stop, n_stop;

    logic [pta_pkg::WIDTH_W-1:0] prod_avg;
    logic [pta_pkg::WIDTH_W:0]   rem_sh;
    logic                        out_free;
    logic [pta_pkg::WIDTH_W-1:0] mag_ext;

    assign prod_avg = r_prod[SHIFT + pta_pkg::WIDTH_W - 1:SHIFT];
    assign rem_sh   = {r_rem, r_quo[18]};
    assign out_free = !r_ov || i_out_ready;
    assign mag_ext  = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pta_pkg::B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_out  <= n_out;
        r_job  <= n_job;
        r_prod <= n_prod;
        r_avg  <= n_avg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_stop <= n_stop;
    end

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !i_out_ready;
        n_out   = r_out;
        n_job   = r_job;
        n_prod  = r_prod;
        n_avg   = r_avg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_stop  = r_stop;
        o_pop   = 1'b0;
        case (r_state)
            pta_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_state = pta_pkg::B_MUL;
                end
            end
            pta_pkg::B_MUL: begin
                n_prod  = PROD_W'(r_job.sum) * PROD_W'(RECIP);
                n_state = pta_pkg::B_PREP;
            end
            pta_pkg::B_PREP: begin
                n_avg  = prod_avg;
                n_stop = (prod_avg == i_slowest);
                n_rem  = '0;
                n_cnt  = '0;
                if (prod_avg == i_slowest) begin
                    n_quo = '0;
                    n_cnt = pta_pkg::DIV_CNT_W'(pta_pkg::DIV_STEPS);
                end else if (prod_avg == '0) begin
                    n_quo = pta_pkg::SPEED_NUM;
                    n_cnt = pta_pkg::DIV_CNT_W'(pta_pkg::DIV_STEPS);
                end else begin
                    n_quo = pta_pkg::SPEED_NUM;
                end
                n_state = pta_pkg::B_DIV;
            end
            pta_pkg::B_DIV: begin
                if (r_cnt != pta_pkg::DIV_CNT_W'(pta_pkg::DIV_STEPS)) begin
                    if (rem_sh >= {1'b0, r_avg}) begin
                        n_rem = pta_pkg::WIDTH_W'(rem_sh - {1'b0, r_avg});
                        n_quo = {r_quo[17:0], 1'b1};
                    end else begin
                        n_rem = rem_sh[pta_pkg::WIDTH_W-1:0];
                        n_quo = {r_quo[17:0], 1'b0};
                    end
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    n_ov                = 1'b1;
                    n_out.avg_width     = r_avg;
                    n_out.speed_q4      = r_job.reverse_dir ? -$signed(mag_ext)
                                                            : $signed(mag_ext);
                    n_out.window_filled = r_job.filled;
                    n_out.stopped       = r_stop;
                    n_state             = pta_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = pta_pkg::B_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[tb/tb_pulse_tachometer_average_rpm.sv]
// Self-checking testbench for pulse_tachometer_average_rpm: predicts the windowed
// average pulse width and the signed Q.4 speed of every transaction and checks each one.
// Depends on pta_pkg and the pulse_tachometer_average_rpm RTL only.
module tb_pulse_tachometer_average_rpm;

    import pta_pkg::*;

    // The block runs with its default ring size, and the predictor mirrors it.
    localparam int RING_LEN   = WINDOW_DEF;
    localparam int QUIET_MAX  = 3000;
    localparam int SETTLE_CYC = 30;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 125;
    localparam logic [WIDTH_W-1:0] W_MAX = '1;

    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_idx   = REG_FASTEST;
    logic [WIDTH_W-1:0]   cfg_data  = '0;

    pulse_tachometer_average_rpm #(
        .WINDOW(RING_LEN)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Clock with a period of 8 time units.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Pulse measurements waiting to be offered to the block, and the tachometer
    // readings that accepted measurements are known to produce, oldest first.
    t_in  pulse_backlog[$];
    t_out awaited_rpm[$];

    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    // When set, neither side inserts gaps, so the block sees back-to-back traffic.
    bit   steady_flow    = 1'b0;

    // Shadow copy of the tachometer: register values and window state.
    logic [WIDTH_W-1:0] fastest_cfg = FASTEST_RST;
    logic [WIDTH_W-1:0] slowest_cfg = SLOWEST_RST;
    logic [WIDTH_W-1:0] ring [RING_LEN] = '{default: '0};
    logic [SUM_W-1:0]   run_sum   = '0;
    int                 ring_pos  = 0;
    bit                 ring_full = 1'b0;

    // Folds one measurement into the shadow window and returns the reading that the
    // block must report for it. The window state is only touched here, once per transaction.
    function automatic t_out average_speed(t_in item);
        t_out               res;
        logic [WIDTH_W-1:0] qual;
        logic [SUM_W-1:0]   quot;
        logic [WIDTH_W-1:0] avg;
        logic [WIDTH_W-1:0] mag;
        qual = item.pulse_width;
        // Anything faster than the fastest believable pulse, a timeout of zero
        // included, is read as a stall and stands in the window as the slowest pulse.
        if (qual < fastest_cfg)
            qual = slowest_cfg;
        run_sum        = run_sum - ring[ring_pos] + qual;
        ring[ring_pos] = qual;
        ring_pos       = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
        // The fill flag is sticky once the advanced index reaches the last slot.
        if (ring_pos == RING_LEN - 1)
            ring_full = 1'b1;
        quot = SUM_W'(run_sum / RING_LEN);
        avg  = quot[WIDTH_W-1:0];
        res.avg_width     = avg;
        res.window_filled = ring_full;
        res.stopped       = (avg == slowest_cfg);
        if (res.stopped)
            mag = '0;
        else if (avg == '0)
            mag = {1'b0, SPEED_NUM};   // zero average saturates to full speed
        else
            mag = {1'b0, SPEED_NUM} / avg;
        res.speed_q4 = item.reverse_dir ? ('0 - mag) : mag;
        return res;
    endfunction

    // Input side. A measurement is accepted when valid and ready meet at an edge;
    // the expected reading is produced at that same edge. After each transaction a
    // gap is drawn, none under steady flow, before the next measurement is offered.
    // Valid is only ever assigned once per edge, so a measurement that follows
    // directly keeps valid high and just swaps the payload.
    int gap_left = 0;
    always @(posedge i_clk) begin : pulse_driver
        logic fire;
        int   wait_left;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            fire = in_valid && in_ready;
            if (fire)
                awaited_rpm.push_back(average_speed(in_data));
            if (!in_valid || fire) begin
                if (fire)
                    wait_left = steady_flow ? 0 : $urandom_range(0, 19);
                else
                    wait_left = gap_left;
                if (wait_left != 0 || pulse_backlog.size() == 0) begin
                    in_valid <= 1'b0;
                    gap_left <= (wait_left != 0) ? wait_left - 1 : 0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= pulse_backlog.pop_front();
                end
            end
        end
    end

    task automatic flag_field(input string field, input logic [WIDTH_W-1:0] want,
                              input logic [WIDTH_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Output side. Every accepted reading is checked field by field against the
    // oldest expectation. After each transaction ready may drop for a random stall unless steady flow is set.
    int stall_left = 0;
    always @(posedge i_clk) begin : rpm_monitor
        t_out want;
        int   stall;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && out_ready) begin
            if (awaited_rpm.size() == 0) begin
                $display("%0t: unexpected reading, expected none, actual avg %h speed %h",
                         $time, out_data.avg_width, out_data.speed_q4);
                mismatch_count++;
            end else begin
                want = awaited_rpm.pop_front();
                if (out_data.avg_width !== want.avg_width)
                    flag_field("avg_width", want.avg_width, out_data.avg_width);
                if (out_data.speed_q4 !== want.speed_q4)
                    flag_field("speed_q4", want.speed_q4, out_data.speed_q4);
                if (out_data.window_filled !== want.window_filled)
                    flag_field("window_filled", WIDTH_W'(want.window_filled),
                               WIDTH_W'(out_data.window_filled));
                if (out_data.stopped !== want.stopped)
                    flag_field("stopped", WIDTH_W'(want.stopped),
                               WIDTH_W'(out_data.stopped));
            end
            stall      = steady_flow ? 0 : $urandom_range(0, 19);
            stall_left <= stall;
            out_ready  <= (stall == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: a run in which no transaction moves on either channel for too long
    // is hung. The pauses around register writes are far shorter than the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_pulse_tachometer_average_rpm: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_pulse(input logic [WIDTH_W-1:0] width, input logic rev);
        t_in item;
        item.pulse_width = width;
        item.reverse_dir = rev;
        pulse_backlog.push_back(item);
    endtask

    // Waits until every measurement has been taken and every reading checked, then
    // lets the back end settle before anything else happens.
    task automatic drain();
        while (pulse_backlog.size() != 0 || in_valid || awaited_rpm.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Writes both thresholds on consecutive edges. Only called while the block is idle.
    task automatic program_regs(input logic [WIDTH_W-1:0] fast, input logic [WIDTH_W-1:0] slow);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FASTEST;
        cfg_data <= fast;
        @(posedge i_clk);
        cfg_idx  <= REG_SLOWEST;
        cfg_data <= slow;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        fastest_cfg = fast;
        slowest_cfg = slow;
    endtask

    // One random phase. Most traffic is runs of timeouts, slowest-pulse widths or tiny widths, which is
    // what pushes the average onto the stopped value or down to zero; the rest is
    // single widths near both thresholds, small widths and widths across the full field.
    task automatic fill_random(input int count);
        int pushed;
        int pick;
        int run;
        logic [WIDTH_W-1:0] w;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // A burst of timeouts or of widths equal to the slowest pulse.
                run = $urandom_range(RING_LEN, RING_LEN + 2);
                repeat (run) begin
                    w = $urandom_range(0, 1) ? slowest_cfg : '0;
                    queue_pulse(w, 1'($urandom_range(0, 1)));
                end
                pushed += run;
            end else if (pick < 22) begin
                // Tiny widths; with a low fastest threshold the average reaches zero.
                run = RING_LEN;
                repeat (run) queue_pulse(WIDTH_W'($urandom_range(0, 9)),
                                         1'($urandom_range(0, 1)));
                pushed += run;
            end else begin
                case ($urandom_range(0, 4))
                    0: w = fastest_cfg + WIDTH_W'($urandom_range(0, 2)) - 1'b1;
                    1: w = slowest_cfg + WIDTH_W'($urandom_range(0, 2)) - 1'b1;
                    2: w = WIDTH_W'($urandom_range(0, 15));
                    default: w = WIDTH_W'($urandom_range(0, int'(W_MAX)));
                endcase
                queue_pulse(w, 1'($urandom_range(0, 1)));
                pushed++;
            end
        end
    endtask

    // Threshold pairs for the random phases: all four corners of the register
    // ranges, the reset values, a narrow band and two random draws.
    logic [WIDTH_W-1:0] fast_set [PHASES];
    logic [WIDTH_W-1:0] slow_set [PHASES];

    initial begin
        fast_set = '{20'd0, W_MAX, 20'd0, W_MAX, FASTEST_RST, 20'd0, 20'd5000, 20'd0};
        slow_set = '{20'd1, W_MAX, W_MAX, 20'd1, SLOWEST_RST, 20'd0, 20'd20, 20'd0};
        fast_set[5] = WIDTH_W'($urandom_range(0, int'(W_MAX)));
        slow_set[5] = WIDTH_W'($urandom_range(1, int'(W_MAX)));
        fast_set[7] = WIDTH_W'($urandom_range(0, 2000));
        slow_set[7] = WIDTH_W'($urandom_range(1, 200000));

        // Reset is held once, at the start of the run.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset thresholds: a timeout, just below and at the fastest
        // pulse, the widest pulse, a width above the slowest one (kept as is), then
        // ten timeouts so the whole window holds the slowest pulse and the motor
        // reads as stopped. The fill flag comes up on the way.
        queue_pulse('0, 1'b0);
        queue_pulse(FASTEST_RST - 1'b1, 1'b1);
        queue_pulse(FASTEST_RST, 1'b0);
        queue_pulse(W_MAX, 1'b1);
        queue_pulse(SLOWEST_RST + 20'd1, 1'b0);
        repeat (RING_LEN) queue_pulse('0, 1'($urandom_range(0, 1)));
        drain();

        // Directed, no fastest threshold: zero widths are kept, so the average
        // falls to zero on the last pulse and the speed saturates in the reverse direction.
        program_regs('0, 20'd1);
        repeat (RING_LEN - 1) queue_pulse('0, 1'b0);
        queue_pulse('0, 1'b1);
        drain();

        // Random phases, two of them with back-to-back traffic on both sides.
        for (int p = 0; p < PHASES; p++) begin
            steady_flow = (p == 2 || p == 5);
            program_regs(fast_set[p], slow_set[p]);
            fill_random(PHASE_LEN);
            drain();
        end

        if (mismatch_count == 0)
            $display("tb_pulse_tachometer_average_rpm: clean");
        else
            $display("tb_pulse_tachometer_average_rpm: errors");
        $finish;
    end

endmodule
